FILE: hdl/acd_pkg.sv
// ----------------------------------------------------------------------------
// acd_pkg: shared types and constants of the escape command decoder
// command codes, controller/datapath signal groups and the sgr code table
// ----------------------------------------------------------------------------
package acd_pkg;

    // screen command codes
    localparam logic [4:0] CMD_CHAR       = 5'd0;
    localparam logic [4:0] CMD_BELL       = 5'd1;
    localparam logic [4:0] CMD_BS         = 5'd2;
    localparam logic [4:0] CMD_TAB        = 5'd3;
    localparam logic [4:0] CMD_LF         = 5'd4;
    localparam logic [4:0] CMD_CR         = 5'd5;
    localparam logic [4:0] CMD_CLEAR      = 5'd6;
    localparam logic [4:0] CMD_SAVE       = 5'd7;
    localparam logic [4:0] CMD_RESTORE    = 5'd8;
    localparam logic [4:0] CMD_MOVE       = 5'd9;
    localparam logic [4:0] CMD_ROWREL     = 5'd10;
    localparam logic [4:0] CMD_SETPOS     = 5'd11;
    localparam logic [4:0] CMD_ED         = 5'd12;
    localparam logic [4:0] CMD_EL         = 5'd13;
    localparam logic [4:0] CMD_ATTR_RESET = 5'd14;
    localparam logic [4:0] CMD_ATTR       = 5'd15;
    localparam logic [4:0] CMD_FG         = 5'd16;
    localparam logic [4:0] CMD_BG         = 5'd17;

    // parser modes
    localparam logic [1:0] MODE_GROUND = 2'd0;
    localparam logic [1:0] MODE_ESCAPE = 2'd1;
    localparam logic [1:0] MODE_CSI    = 2'd2;
    localparam logic [1:0] MODE_OSC    = 2'd3;

    // byte codes
    localparam logic [7:0] BYTE_ESC = 8'h1B;
    localparam logic [7:0] BYTE_BEL = 8'h07;
    localparam logic [7:0] BYTE_CR  = 8'h0D;

    // results per byte
    localparam int MaxOut = 16;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic move;
        logic walk_step;
    } t_ctrl_cmd;

    // datapath to controller status
    typedef struct packed {
        logic res_valid;
        logic res_has;
        logic out_free;
        logic sgr_req;
        logic walk_at_end;
        logic walk_stall;
    } t_dp_stat;

    // one decoded result
    typedef struct packed {
        logic        hit;
        logic [4:0]  cmd;
        logic [16:0] a;
        logic [16:0] b;
    } t_result;

    // sgr code to command
    function automatic t_result sgr_decode(input logic [15:0] c);
        t_result r;
        r.hit = 1'b1;
        r.cmd = CMD_ATTR;
        r.a   = '0;
        r.b   = '0;
        if (c == 16'd0) begin
            r.cmd = CMD_ATTR_RESET;
        end else if (c == 16'd1) begin
            r.b = 17'd1;
        end else if (c == 16'd4) begin
            r.a = 17'd1; r.b = 17'd1;
        end else if (c == 16'd7) begin
            r.a = 17'd2; r.b = 17'd1;
        end else if (c == 16'd22) begin
            r.a = 17'd0;
        end else if (c == 16'd24) begin
            r.a = 17'd1;
        end else if (c == 16'd27) begin
            r.a = 17'd2;
        end else if (c >= 16'd30 && c <= 16'd37) begin
            r.cmd = CMD_FG; r.a = 17'(c - 16'd30);
        end else if (c == 16'd39) begin
            r.cmd = CMD_FG; r.a = 17'd255;
        end else if (c >= 16'd40 && c <= 16'd47) begin
            r.cmd = CMD_BG; r.a = 17'(c - 16'd40);
        end else if (c == 16'd49) begin
            r.cmd = CMD_BG; r.a = 17'd255;
        end else if (c >= 16'd90 && c <= 16'd97) begin
            r.cmd = CMD_FG; r.a = 17'(c - 16'd82);
        end else if (c >= 16'd100 && c <= 16'd107) begin
            r.cmd = CMD_BG; r.a = 17'(c - 16'd92);
        end else begin
            r.hit = 1'b0;
        end
        return r;
    endfunction

endpackage

FILE: hdl/acd_intf.sv
// ----------------------------------------------------------------------------
// acd_intf: byte and command channels of the escape command decoder
// valid/ready channels with source and sink modports
// ----------------------------------------------------------------------------
interface acd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface acd_out_if;
    logic               valid;
    logic               ready;
    logic [4:0]         command;
    logic signed [16:0] arg_first;
    logic signed [16:0] arg_second;
    logic               last_of_run;
    modport source (output valid, output command, output arg_first, output arg_second,
                    output last_of_run, input ready);
    modport sink   (input valid, input command, input arg_first, input arg_second,
                    input last_of_run, output ready);
endinterface

FILE: hdl/acd_ctrl.sv
// ----------------------------------------------------------------------------
// acd_ctrl: controller of the escape command decoder
// sequences byte transfers, result moves and the sgr parameter walk
// ----------------------------------------------------------------------------
module acd_ctrl
    import acd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_dp_stat  i_stat,
    output logic      o_in_ready,
    output t_ctrl_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WALK = 1'b1;

    logic r_state;
    logic n_state;

    // handshake and commands
    always_comb begin
        o_in_ready      = (r_state == S_IDLE) && !i_stat.res_valid;
        o_cmd.accept    = o_in_ready && i_in_valid;
        o_cmd.move      = i_stat.res_valid && i_stat.out_free;
        o_cmd.walk_step = (r_state == S_WALK) && !i_stat.walk_stall;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.accept && i_stat.sgr_req) n_state = S_WALK;
            end
            S_WALK: begin
                if (o_cmd.walk_step && i_stat.walk_at_end) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

endmodule

FILE: hdl/acd_datapath.sv
// ----------------------------------------------------------------------------
// acd_datapath: parser state, parameter store and result registers
// decodes one byte per transfer and walks stored parameters for sgr
// ----------------------------------------------------------------------------
module acd_datapath
    import acd_pkg::*;
#(
    parameter int MAX_PARAMS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [7:0]         i_byte,
    input  t_ctrl_cmd          i_cmd,
    input  logic               i_out_ready,
    output t_dp_stat           o_stat,
    output logic               o_out_valid,
    output logic [4:0]         o_command,
    output logic signed [16:0] o_arg_first,
    output logic signed [16:0] o_arg_second,
    output logic               o_last_of_run
);

    localparam int CW = $clog2(MAX_PARAMS + 1);
    localparam int IW = $clog2(MAX_PARAMS);

    // parser state
    logic [1:0]  r_mode, n_mode;
    logic        r_priv, n_priv;
    logic        r_body, n_body;
    logic        r_frozen, n_frozen;
    logic [CW-1:0] r_count, n_count;
    logic [15:0] r_cur, n_cur;
    logic        r_pres, n_pres;
    logic [1:0]  r_pend, n_pend;
    logic [20:0] r_acc, n_acc;
    logic [1:0]  r_ulen, n_ulen;
    logic [15:0] r_p0, n_p0;
    logic [15:0] r_p1, n_p1;
    logic [15:0] r_param [MAX_PARAMS];

    // walk state
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_wlen, n_wlen;
    logic [4:0]    r_nres, n_nres;
    logic          r_hv, n_hv;
    t_result       r_held, n_held;

    // result and output registers
    logic          r_rv, n_rv;
    t_result       r_res, n_res;
    logic          r_rlast, n_rlast;
    logic          r_ov;

    // byte decode signals
    t_result       step_res;
    logic          sgr_req;
    logic          push_en;
    logic [15:0]   push_v;
    logic [CW-1:0] eff_cnt;
    logic [15:0]   eff_p0, eff_p1, por0, por1;
    logic [19:0]   mul10;
    logic [20:0]   cont_acc;
    logic [20:0]   cp;
    logic [16:0]   unit;
    logic [7:0]    b;
    logic          is_digit, is_final;

    assign b        = i_byte;
    assign is_digit = (b >= 8'h30) && (b <= 8'h39);
    assign is_final = (b >= 8'h40) && (b <= 8'h7E);
    assign push_v   = r_pres ? r_cur : 16'd0;
    assign mul10    = {1'b0, r_cur, 3'b000} + {3'b000, r_cur, 1'b0} + {16'd0, b[3:0]};
    assign cont_acc = (b[7:6] == 2'b10) ? {r_acc[14:0], b[5:0]} : 21'd0;

    // effective parameters once this byte is folded in
    always_comb begin
        push_en = (r_mode == MODE_CSI) && !(!r_body && b == 8'h3F) && !r_frozen
                  && !is_digit && (r_count < CW'(MAX_PARAMS));
        eff_cnt = r_count + CW'(push_en);
        eff_p0  = (push_en && r_count == CW'(0)) ? push_v : r_p0;
        eff_p1  = (push_en && r_count == CW'(1)) ? push_v : r_p1;
        por0    = (eff_cnt > CW'(0) && eff_p0 != 16'd0) ? eff_p0 : 16'd1;
        por1    = (eff_cnt > CW'(1) && eff_p1 != 16'd0) ? eff_p1 : 16'd1;
    end

    // utf-8 completion value
    always_comb begin
        cp   = cont_acc;
        unit = 17'hFFFD;
        if (r_ulen == 2'd1) begin
            if (cp >= 21'h80) unit = cp[16:0];
        end else if (r_ulen == 2'd2) begin
            if (cp >= 21'h800 && (cp < 21'hD800 || cp > 21'hDFFF)) unit = cp[16:0];
        end else begin
            if (cp >= 21'h10000 && cp <= 21'h10FFFF)
                unit = 17'h0D800 + 17'((cp - 21'h10000) >> 10);
        end
    end

    // per byte parser step
    always_comb begin
        n_mode   = r_mode;
        n_priv   = r_priv;
        n_body   = r_body;
        n_frozen = r_frozen;
        n_count  = r_count;
        n_cur    = r_cur;
        n_pres   = r_pres;
        n_pend   = r_pend;
        n_acc    = r_acc;
        n_ulen   = r_ulen;
        n_p0     = r_p0;
        n_p1     = r_p1;
        step_res = '0;
        sgr_req  = 1'b0;
        unique case (r_mode)
            MODE_GROUND: begin
                if (b == BYTE_ESC) begin
                    n_mode = MODE_ESCAPE;
                end else if (b < 8'h20) begin
                    step_res.hit = 1'b1;
                    if (b == BYTE_BEL)                     step_res.cmd = CMD_BELL;
                    else if (b == 8'h08)                   step_res.cmd = CMD_BS;
                    else if (b == 8'h09)                   step_res.cmd = CMD_TAB;
                    else if (b >= 8'h0A && b <= 8'h0C)     step_res.cmd = CMD_LF;
                    else if (b == BYTE_CR)                 step_res.cmd = CMD_CR;
                    else                                   step_res.hit = 1'b0;
                end else if (b < 8'h80) begin
                    step_res.hit = 1'b1;
                    step_res.cmd = CMD_CHAR;
                    step_res.a   = {9'd0, b};
                end else if (r_pend == 2'd0) begin
                    if ((b & 8'hE0) == 8'hC0) begin
                        n_ulen = 2'd1; n_pend = 2'd1; n_acc = {16'd0, b[4:0]};
                    end else if ((b & 8'hF0) == 8'hE0) begin
                        n_ulen = 2'd2; n_pend = 2'd2; n_acc = {17'd0, b[3:0]};
                    end else if ((b & 8'hF8) == 8'hF0) begin
                        n_ulen = 2'd3; n_pend = 2'd3; n_acc = {18'd0, b[2:0]};
                    end else begin
                        step_res.hit = 1'b1;
                        step_res.cmd = CMD_CHAR;
                        step_res.a   = 17'h3F;
                    end
                end else begin
                    n_acc  = cont_acc;
                    n_pend = r_pend - 2'd1;
                    if (r_pend == 2'd1) begin
                        n_acc  = '0;
                        n_ulen = '0;
                        step_res.hit = 1'b1;
                        step_res.cmd = CMD_CHAR;
                        step_res.a   = unit;
                    end
                end
            end
            MODE_ESCAPE: begin
                n_mode = MODE_GROUND;
                if (b == 8'h5B) begin
                    n_mode = MODE_CSI;
                    n_priv = 1'b0; n_body = 1'b0; n_frozen = 1'b0;
                    n_count = '0; n_cur = '0; n_pres = 1'b0;
                end else if (b == 8'h5D) begin
                    n_mode = MODE_OSC;
                end else if (b == 8'h63) begin
                    step_res.hit = 1'b1; step_res.cmd = CMD_CLEAR;
                end else if (b == 8'h37) begin
                    step_res.hit = 1'b1; step_res.cmd = CMD_SAVE;
                end else if (b == 8'h38) begin
                    step_res.hit = 1'b1; step_res.cmd = CMD_RESTORE;
                end
            end
            MODE_CSI: begin
                if (!r_body && b == 8'h3F) begin
                    n_priv = 1'b1;
                end else begin
                    n_body = 1'b1;
                    if (!r_frozen) begin
                        if (is_digit) begin
                            n_cur  = (mul10 > 20'd65535) ? 16'hFFFF : mul10[15:0];
                            n_pres = 1'b1;
                        end else begin
                            n_count = eff_cnt;
                            n_p0    = eff_p0;
                            n_p1    = eff_p1;
                            n_cur   = '0;
                            n_pres  = 1'b0;
                            if (b != 8'h3B) n_frozen = 1'b1;
                        end
                    end
                    if (is_final) begin
                        if (!r_priv) begin
                            step_res.hit = 1'b1;
                            case (b)
                                8'h41: begin
                                    step_res.cmd = CMD_MOVE;
                                    step_res.a   = 17'd0 - {1'b0, por0};
                                end
                                8'h42: begin
                                    step_res.cmd = CMD_MOVE; step_res.a = {1'b0, por0};
                                end
                                8'h43: begin
                                    step_res.cmd = CMD_MOVE; step_res.b = {1'b0, por0};
                                end
                                8'h44: begin
                                    step_res.cmd = CMD_MOVE;
                                    step_res.b   = 17'd0 - {1'b0, por0};
                                end
                                8'h45: begin
                                    step_res.cmd = CMD_ROWREL; step_res.a = {1'b0, por0};
                                end
                                8'h46: begin
                                    step_res.cmd = CMD_ROWREL;
                                    step_res.a   = 17'd0 - {1'b0, por0};
                                end
                                8'h47: begin
                                    step_res.cmd = CMD_ROWREL;
                                    step_res.b   = {1'b0, por0 - 16'd1};
                                end
                                8'h48, 8'h66: begin
                                    step_res.cmd = CMD_SETPOS;
                                    step_res.a   = {1'b0, por0 - 16'd1};
                                    step_res.b   = {1'b0, por1 - 16'd1};
                                end
                                8'h4A: begin
                                    step_res.cmd = CMD_ED;
                                    step_res.a = (eff_cnt > CW'(0)) ? {1'b0, eff_p0} : 17'd0;
                                end
                                8'h4B: begin
                                    step_res.cmd = CMD_EL;
                                    step_res.a = (eff_cnt > CW'(0)) ? {1'b0, eff_p0} : 17'd0;
                                end
                                8'h73: step_res.cmd = CMD_SAVE;
                                8'h75: step_res.cmd = CMD_RESTORE;
                                8'h6D: begin
                                    step_res.hit = 1'b0;
                                    sgr_req      = 1'b1;
                                end
                                default: step_res.hit = 1'b0;
                            endcase
                        end
                        n_mode = MODE_GROUND;
                        n_priv = 1'b0; n_body = 1'b0; n_frozen = 1'b0;
                        n_count = '0; n_cur = '0; n_pres = 1'b0;
                    end
                end
            end
            default: begin
                if (b == BYTE_BEL)      n_mode = MODE_GROUND;
                else if (b == BYTE_ESC) n_mode = MODE_ESCAPE;
            end
        endcase
    end

    // sgr walk and result staging
    t_result walk_res;
    logic    walk_take;
    logic    res_free;

    assign walk_res  = sgr_decode(r_param[r_idx[IW-1:0]]);
    assign res_free  = !r_rv || i_cmd.move;
    assign walk_take = walk_res.hit && (r_nres < 5'(MaxOut));

    always_comb begin
        n_idx   = r_idx;
        n_wlen  = r_wlen;
        n_nres  = r_nres;
        n_hv    = r_hv;
        n_held  = r_held;
        n_rv    = r_rv && !i_cmd.move;
        n_res   = r_res;
        n_rlast = r_rlast;
        if (i_cmd.accept) begin
            if (step_res.hit) begin
                n_rv = 1'b1; n_res = step_res; n_rlast = 1'b1;
            end
            if (sgr_req) begin
                n_idx = '0; n_wlen = eff_cnt; n_nres = '0; n_hv = 1'b0;
            end
        end else if (i_cmd.walk_step) begin
            if (r_idx == r_wlen) begin
                if (r_hv) begin
                    n_rv = 1'b1; n_res = r_held; n_rlast = 1'b1; n_hv = 1'b0;
                end
            end else begin
                n_idx = r_idx + CW'(1);
                if (walk_take) begin
                    n_nres = r_nres + 5'd1;
                    if (r_hv) begin
                        n_rv = 1'b1; n_res = r_held; n_rlast = 1'b0;
                    end
                    n_held = walk_res;
                    n_hv   = 1'b1;
                end
            end
        end
    end

    // status toward the controller
    always_comb begin
        o_stat.res_valid   = r_rv;
        o_stat.res_has     = step_res.hit;
        o_stat.out_free    = !r_ov || i_out_ready;
        o_stat.sgr_req     = sgr_req;
        o_stat.walk_at_end = (r_idx == r_wlen);
        o_stat.walk_stall  = r_hv && !res_free && ((r_idx == r_wlen) || walk_take);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_GROUND; r_priv <= 1'b0; r_body <= 1'b0; r_frozen <= 1'b0;
            r_count <= '0; r_cur <= '0; r_pres <= 1'b0;
            r_pend <= '0; r_acc <= '0; r_ulen <= '0;
            r_idx <= '0; r_wlen <= '0; r_nres <= '0; r_hv <= 1'b0;
            r_rv <= 1'b0; r_ov <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_mode <= n_mode; r_priv <= n_priv; r_body <= n_body;
                r_frozen <= n_frozen; r_count <= n_count; r_cur <= n_cur;
                r_pres <= n_pres; r_pend <= n_pend; r_acc <= n_acc; r_ulen <= n_ulen;
            end
            r_idx <= n_idx; r_wlen <= n_wlen; r_nres <= n_nres; r_hv <= n_hv;
            r_rv  <= n_rv;
            if (i_cmd.move)       r_ov <= 1'b1;
            else if (i_out_ready) r_ov <= 1'b0;
        end
    end

    // payload registers and parameter store
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_p0 <= n_p0;
            r_p1 <= n_p1;
            if (push_en) r_param[r_count[IW-1:0]] <= push_v;
        end
        r_held  <= n_held;
        r_res   <= n_res;
        r_rlast <= n_rlast;
        if (i_cmd.move) begin
            o_command     <= r_res.cmd;
            o_arg_first   <= r_res.a;
            o_arg_second  <= r_res.b;
            o_last_of_run <= r_rlast;
        end
    end

    assign o_out_valid = r_ov;

endmodule

FILE: hdl/ansi_escape_command_decoder_unit.sv
// ----------------------------------------------------------------------------
// ansi_escape_command_decoder_unit: terminal byte to screen command decoder
// parses ground, escape, csi and osc bytes with utf-8 decoding
// ----------------------------------------------------------------------------
// One byte is taken per transfer. A byte that gives one command holds the
// input off until that command moves from the staging register to the output
// register; a byte that gives no command does not hold it off. An sgr final byte
// ('m') walks the stored parameters through one store read a cycle while the
// output side does not stall.
// Results pass through a staging register and an output register, so a new
// byte can be taken while a command still waits on the output.
module ansi_escape_command_decoder_unit
    import acd_pkg::*;
#(
    parameter int MAX_PARAMS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    acd_in_if.sink       i_in,
    acd_out_if.source    o_out
);

    t_ctrl_cmd cmd;
    t_dp_stat  stat;

    // controller
    acd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (stat),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    // datapath
    acd_datapath #(.MAX_PARAMS(MAX_PARAMS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte        (i_in.data_byte),
        .i_cmd         (cmd),
        .i_out_ready   (o_out.ready),
        .o_stat        (stat),
        .o_out_valid   (o_out.valid),
        .o_command     (o_out.command),
        .o_arg_first   (o_out.arg_first),
        .o_arg_second  (o_out.arg_second),
        .o_last_of_run (o_out.last_of_run)
    );

    // a moved result shows on the output next cycle
    a_move_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.move |=> o_out.valid) else $error("moved result not on output");

    // a decoded byte result is staged next cycle
    a_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.accept && stat.res_has |=> stat.res_valid) else $error("result not staged");

    // no byte transfer while the walk runs
    a_no_accept_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.walk_step |-> !cmd.accept) else $error("transfer during walk");

endmodule
